// ----- rtl/core/cteb_pkg.sv -----
// cteb_pkg: shared codes for the gap-buffer text editor.
// Holds the command, result-kind, status and sequencer state encodings.
// No dependencies.
package cteb_pkg;

  // Command codes on in_func; codes 5 to 7 carry no meaning.
  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_LEFT   = 3'd1,
    FN_RIGHT  = 3'd2,
    FN_BACK   = 3'd3,
    FN_FLUSH  = 3'd4
  } func_t;

  // Result kinds on out_kind.
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  // Edit status codes on out_status.
  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_BOUND = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MOVE  = 2'd1,
    S_FLUSH = 2'd2
  } state_t;

  localparam int unsigned CHAR_W = 8;

endpackage

// ----- rtl/core/cteb_store.sv -----
// cteb_store: character store of the gap buffer, one write and one read port.
// The read data is registered.
// Depends on cteb_pkg for the character width.
module cteb_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [cteb_pkg::CHAR_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [cteb_pkg::CHAR_W-1:0] rdata_r
);

  logic [cteb_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/cursor_text_edit_buffer_unit.sv -----
// cursor_text_edit_buffer_unit: line-editing buffer with a cursor, kept as a gap buffer.
// Instantiates cteb_store for the characters; uses codes from cteb_pkg.
//
// Usage:
//   Input channel: drive in_func / in_char_in and raise start; the command transfers
//   at the rising edge where start is high and busy is low.
//   Result channel: each result sits on out_kind / out_status / out_char_out / out_last
//   for exactly one cycle, marked by out_valid. The receiver cannot stall; every
//   result transfers at the edge that ends its cycle.
//   Latency and throughput:
//   - insert, backspace, boundary cases, unused codes and flush of an empty buffer:
//     result in the cycle after the transfer, busy stays low, so one command per cycle.
//   - cursor left / right: the store's read is registered, so busy is high for one cycle
//     (read, then write back in S_MOVE); the status is registered after the write-back.
//     No new command transfers while busy is high.
//   - flush of N characters: one store read per character; busy is high in S_FLUSH;
//     characters stream one per cycle from the store's read register, the last
//     one marked by out_last. A new command may transfer while the last one is shown.
//   Reset (rst_n low, synchronous): both counts clear, the buffer is empty and the
//   sequencer idles. Store contents are left as they are; only written entries are read.
//   Busy also interlocks the store: a read and a write never hit one entry in one cycle.
module cursor_text_edit_buffer_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_func,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  output logic [1:0] out_kind,
  output logic [1:0] out_status,
  output logic [7:0] out_char_out,
  output logic       out_last
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // Sequencer and counts
  cteb_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic [CW-1:0]    right_r, right_nxt;
  logic [CW-1:0]    k_r, k_nxt;          // flush position in text order
  logic [AW-1:0]    mv_addr_r, mv_addr_nxt; // write-back address of a cursor move
  logic             mv_left_r, mv_left_nxt;

  // Result registers
  logic              out_valid_r, out_valid_nxt;
  cteb_pkg::kind_t   out_kind_r, out_kind_nxt;
  cteb_pkg::status_t out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  // Store port
  logic                        st_we, st_re;
  logic [AW-1:0]               st_waddr, st_raddr;
  logic [cteb_pkg::CHAR_W-1:0] st_wdata, st_rdata;

  logic          accept;
  logic [CW-1:0] total, gap;
  logic          is_full, move_go, flush_go, flush_end;

  assign accept    = start && !busy;
  assign total     = left_r + right_r;
  assign gap       = CAP_C - total;
  assign is_full   = (total == CAP_C);
  // Cursor moves that actually shift a character need a read then a write back.
  assign move_go   = accept && (((in_func == cteb_pkg::FN_LEFT) && (left_r != '0)) ||
                                ((in_func == cteb_pkg::FN_RIGHT) && (right_r != '0)));
  assign flush_go  = accept && (in_func == cteb_pkg::FN_FLUSH) && (total != '0);
  assign flush_end = (k_r == total - ONE_C);

  cteb_store #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .we     (st_we),
    .waddr  (st_waddr),
    .wdata  (st_wdata),
    .re     (st_re),
    .raddr  (st_raddr),
    .rdata_r(st_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cteb_pkg::S_IDLE: begin
        if (move_go) begin
          state_nxt = cteb_pkg::S_MOVE;
        end else if (flush_go) begin
          state_nxt = cteb_pkg::S_FLUSH;
        end
      end
      cteb_pkg::S_MOVE: begin
        state_nxt = cteb_pkg::S_IDLE;
      end
      cteb_pkg::S_FLUSH: begin
        if (flush_end) begin
          state_nxt = cteb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cteb_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    busy           = (state_r != cteb_pkg::S_IDLE);
    st_we          = 1'b0;
    st_waddr       = left_r[AW-1:0];
    st_wdata       = in_char_in;
    st_re          = 1'b0;
    st_raddr       = left_r[AW-1:0];
    left_nxt       = left_r;
    right_nxt      = right_r;
    k_nxt          = k_r;
    mv_addr_nxt    = mv_addr_r;
    mv_left_nxt    = mv_left_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = cteb_pkg::KIND_STATUS;
    out_status_nxt = cteb_pkg::STS_DONE;
    out_last_nxt   = 1'b1;

    unique case (state_r)
      cteb_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (in_func)
            cteb_pkg::FN_INSERT: begin
              if (is_full) begin
                out_status_nxt = cteb_pkg::STS_FULL;
              end else begin
                st_we    = 1'b1;
                left_nxt = left_r + ONE_C;
              end
            end
            cteb_pkg::FN_LEFT: begin
              if (left_r == '0) begin
                out_status_nxt = cteb_pkg::STS_BOUND;
              end else begin
                // Fetch the character before the cursor; emit after write-back.
                out_valid_nxt = 1'b0;
                st_re         = 1'b1;
                st_raddr      = AW'(left_r - ONE_C);
                mv_addr_nxt   = AW'(CAP_C - right_r - ONE_C);
                mv_left_nxt   = 1'b1;
              end
            end
            cteb_pkg::FN_RIGHT: begin
              if (right_r == '0) begin
                out_status_nxt = cteb_pkg::STS_BOUND;
              end else begin
                out_valid_nxt = 1'b0;
                st_re         = 1'b1;
                st_raddr      = AW'(CAP_C - right_r);
                mv_addr_nxt   = left_r[AW-1:0];
                mv_left_nxt   = 1'b0;
              end
            end
            cteb_pkg::FN_BACK: begin
              if (left_r == '0) begin
                out_status_nxt = cteb_pkg::STS_BOUND;
              end else begin
                left_nxt = left_r - ONE_C;
              end
            end
            cteb_pkg::FN_FLUSH: begin
              if (total == '0) begin
                out_kind_nxt = cteb_pkg::KIND_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                k_nxt         = '0;
              end
            end
            default: begin
              out_status_nxt = cteb_pkg::STS_BOUND;
            end
          endcase
        end
      end
      cteb_pkg::S_MOVE: begin
        // Write the fetched character across the gap and shift the cursor.
        st_we         = 1'b1;
        st_waddr      = mv_addr_r;
        st_wdata      = st_rdata;
        out_valid_nxt = 1'b1;
        if (mv_left_r) begin
          left_nxt  = left_r - ONE_C;
          right_nxt = right_r + ONE_C;
        end else begin
          left_nxt  = left_r + ONE_C;
          right_nxt = right_r - ONE_C;
        end
      end
      cteb_pkg::S_FLUSH: begin
        // Read one character a cycle; skip the gap once past the left part.
        st_re         = 1'b1;
        st_raddr      = (k_r < left_r) ? k_r[AW-1:0] : AW'(k_r + gap);
        k_nxt         = k_r + ONE_C;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = cteb_pkg::KIND_CHAR;
        out_last_nxt  = flush_end;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cteb_pkg::S_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    mv_addr_r    <= mv_addr_nxt;
    mv_left_r    <= mv_left_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;
  // Characters come straight from the store's read register.
  assign out_char_out = (out_kind_r == cteb_pkg::KIND_CHAR) ? st_rdata : '0;

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, left_r} + {1'b0, right_r}) <= {1'b0, CAP_C})
    else $error("gap buffer counts exceed capacity");

  a_move_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cteb_pkg::S_MOVE) |=>
      (out_valid && (out_kind == cteb_pkg::KIND_STATUS) &&
       (out_status == cteb_pkg::STS_DONE) && out_last))
    else $error("cursor move did not report done");

  a_flush_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cteb_pkg::S_FLUSH) |=> ($stable(left_r) && $stable(right_r)))
    else $error("counts changed during flush");

  a_edit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !move_go && !flush_go) |=> (out_valid && out_last))
    else $error("single-cycle command gave no final result");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == cteb_pkg::S_FLUSH) && flush_end) |=>
      (out_valid && out_last && (state_r == cteb_pkg::S_IDLE)))
    else $error("flush did not end on a marked last character");

endmodule
